/* src/dicd_pkg.sv */
// shared types and class codes for the dual instruction-set class decoder
// no dependencies; imported by every module of the block
package dicd_pkg;

   // input transfer payload
   typedef struct packed {
      logic        command;
      logic [31:0] instruction_word;
   } req_type;

   // result transfer payload
   typedef struct packed {
      logic [4:0] op_class;
      logic       supported;
   } rsp_type;

   // instruction set select codes
   localparam logic SEL_WORD = 1'b0;
   localparam logic SEL_HALF = 1'b1;

   // 32-bit set class codes
   localparam logic [4:0] W_BX     = 5'd0;
   localparam logic [4:0] W_SWP    = 5'd1;
   localparam logic [4:0] W_MUL    = 5'd2;
   localparam logic [4:0] W_MULL   = 5'd3;
   localparam logic [4:0] W_HREG   = 5'd4;
   localparam logic [4:0] W_HIMM   = 5'd5;
   localparam logic [4:0] W_SWI    = 5'd6;
   localparam logic [4:0] W_UNDEF  = 5'd7;
   localparam logic [4:0] W_BRANCH = 5'd8;
   localparam logic [4:0] W_BLOCK  = 5'd9;
   localparam logic [4:0] W_SINGLE = 5'd10;
   localparam logic [4:0] W_PSR    = 5'd11;
   localparam logic [4:0] W_DP     = 5'd12;
   localparam logic [4:0] W_UNSUP  = 5'd13;

   // 16-bit set class codes
   localparam logic [4:0] H_SWI      = 5'd0;
   localparam logic [4:0] H_ADDSP    = 5'd1;
   localparam logic [4:0] H_PUSHPOP  = 5'd2;
   localparam logic [4:0] H_HIREG    = 5'd3;
   localparam logic [4:0] H_ALU      = 5'd4;
   localparam logic [4:0] H_BRANCH   = 5'd5;
   localparam logic [4:0] H_PCLOAD   = 5'd6;
   localparam logic [4:0] H_ADDSUB   = 5'd7;
   localparam logic [4:0] H_LSREG    = 5'd8;
   localparam logic [4:0] H_LSSIGN   = 5'd9;
   localparam logic [4:0] H_LONGBL   = 5'd10;
   localparam logic [4:0] H_CONDB    = 5'd11;
   localparam logic [4:0] H_MULTI    = 5'd12;
   localparam logic [4:0] H_LOADADDR = 5'd13;
   localparam logic [4:0] H_SPLS     = 5'd14;
   localparam logic [4:0] H_LSHALF   = 5'd15;
   localparam logic [4:0] H_LSIMM    = 5'd16;
   localparam logic [4:0] H_MOVIMM   = 5'd17;
   localparam logic [4:0] H_SHIFT    = 5'd18;
   localparam logic [4:0] H_UNSUP    = 5'd19;

   // hi-register op code for branch-exchange
   localparam logic [1:0] HI_OP_BX = 2'b11;

endpackage

/* src/dicd_word_decode.sv */
// class decode for the 32-bit instruction set
// depends on dicd_pkg for class codes and the result struct
module dicd_word_decode
   import dicd_pkg::*;
(
   input  logic [31:0] instruction_word,
   output rsp_type     result
);

   logic [11:0] key;

   // key from opcode bits and the low nibble selector bits
   assign key = {instruction_word[27:20], instruction_word[7:4]};

   // ordered rule list, first match wins
   always_comb begin
      result.supported = 1'b1;
      result.op_class  = W_UNSUP;
      if (key == 12'h121) begin
         result.op_class = W_BX;
      end else if ((key & 12'hFBF) == 12'h109) begin
         result.op_class = W_SWP;
      end else if ((key & 12'hFCF) == 12'h009) begin
         result.op_class = W_MUL;
      end else if ((key & 12'hF8F) == 12'h089) begin
         result.op_class = W_MULL;
      end else if ((key & 12'hE49) == 12'h009) begin
         // halfword transfer with sh of zero is not supported
         if (key[2:1] == 2'b00) begin
            result.supported = 1'b0;
            result.op_class  = W_UNSUP;
         end else begin
            result.op_class = W_HREG;
         end
      end else if ((key & 12'hE49) == 12'h049) begin
         if (key[2:1] == 2'b00) begin
            result.supported = 1'b0;
            result.op_class  = W_UNSUP;
         end else begin
            result.op_class = W_HIMM;
         end
      end else if ((key & 12'hF00) == 12'hF00) begin
         result.op_class = W_SWI;
      end else if ((key & 12'hE01) == 12'h601) begin
         result.supported = 1'b0;
         result.op_class  = W_UNDEF;
      end else if ((key & 12'hE00) == 12'hA00) begin
         result.op_class = W_BRANCH;
      end else if ((key & 12'hE00) == 12'h800) begin
         result.op_class = W_BLOCK;
      end else if ((key & 12'hC00) == 12'h400) begin
         result.op_class = W_SINGLE;
      end else if ((key & 12'hC00) == 12'h000) begin
         // psr transfer lives inside the data processing space
         if ((key & 12'h190) == 12'h100) begin
            result.op_class = W_PSR;
         end else begin
            result.op_class = W_DP;
         end
      end else begin
         // coprocessor space
         result.supported = 1'b0;
         result.op_class  = W_UNSUP;
      end
   end

endmodule

/* src/dicd_half_decode.sv */
// class decode for the 16-bit instruction set
// depends on dicd_pkg for class codes and the result struct
module dicd_half_decode
   import dicd_pkg::*;
(
   input  logic [15:0] halfword,
   output rsp_type     result
);

   logic [9:0] key;
   logic       h1;
   logic       h2;
   logic [1:0] hi_op;
   logic [3:0] cond;

   assign key   = halfword[15:6];
   assign h1    = key[0];
   assign h2    = key[1];
   assign hi_op = key[3:2];
   assign cond  = key[5:2];

   // ordered rule list, first match wins
   always_comb begin
      result.supported = 1'b1;
      result.op_class  = H_UNSUP;
      if ((key & 10'h3FC) == 10'h37C) begin
         result.op_class = H_SWI;
      end else if ((key & 10'h3FC) == 10'h2C0) begin
         result.op_class = H_ADDSP;
      end else if ((key & 10'h3D8) == 10'h2D0) begin
         result.op_class = H_PUSHPOP;
      end else if ((key & 10'h3F0) == 10'h110) begin
         // no hi register named, or bx with h2 set
         if ((hi_op != HI_OP_BX && !h1 && !h2) || (hi_op == HI_OP_BX && h2)) begin
            result.supported = 1'b0;
            result.op_class  = H_UNSUP;
         end else begin
            result.op_class = H_HIREG;
         end
      end else if ((key & 10'h3F0) == 10'h100) begin
         result.op_class = H_ALU;
      end else if ((key & 10'h3E0) == 10'h380) begin
         result.op_class = H_BRANCH;
      end else if ((key & 10'h3E0) == 10'h120) begin
         result.op_class = H_PCLOAD;
      end else if ((key & 10'h3E0) == 10'h060) begin
         result.op_class = H_ADDSUB;
      end else if ((key & 10'h3C8) == 10'h140) begin
         result.op_class = H_LSREG;
      end else if ((key & 10'h3C8) == 10'h148) begin
         result.op_class = H_LSSIGN;
      end else if ((key & 10'h3C0) == 10'h3C0) begin
         result.op_class = H_LONGBL;
      end else if ((key & 10'h3C0) == 10'h340) begin
         // always and never conditions are not conditional branches
         if (cond inside {4'hE, 4'hF}) begin
            result.supported = 1'b0;
            result.op_class  = H_UNSUP;
         end else begin
            result.op_class = H_CONDB;
         end
      end else if ((key & 10'h3C0) == 10'h300) begin
         result.op_class = H_MULTI;
      end else if ((key & 10'h3C0) == 10'h280) begin
         result.op_class = H_LOADADDR;
      end else if ((key & 10'h3C0) == 10'h240) begin
         result.op_class = H_SPLS;
      end else if ((key & 10'h3C0) == 10'h200) begin
         result.op_class = H_LSHALF;
      end else if ((key & 10'h380) == 10'h180) begin
         result.op_class = H_LSIMM;
      end else if ((key & 10'h380) == 10'h080) begin
         result.op_class = H_MOVIMM;
      end else if ((key & 10'h380) == 10'h000) begin
         result.op_class = H_SHIFT;
      end else begin
         result.supported = 1'b0;
         result.op_class  = H_UNSUP;
      end
   end

endmodule

/* src/dual_isa_instruction_class_decoder.sv */
// top level of the dual instruction-set class decoder
// depends on dicd_pkg, dicd_word_decode and dicd_half_decode
//
// usage:
//   req channel carries one instruction per transfer: command selects the
//   32-bit set (0) or the 16-bit set (1, low halfword of instruction_word).
//   rsp channel returns one transfer per instruction: op_class and the
//   supported flag, in request order.
// pipeline: a req transfer loads the input register, then the result register
//   takes its class decode; rsp_valid comes from the result register.
// throughput: 1 instruction per cycle while rsp_stall is low; set by the
//   combinational mask compare chain between the two registers.
// reset: synchronous, clears both valid bits; no result is pending after it.
// stall: when rsp_stall holds a pending result, the input register keeps
//   its item and req_stall rises only once both registers are full; the
//   result payload does not change while stalled.
module dual_isa_instruction_class_decoder
   import dicd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_data_ff;
   logic    out_load;
   logic    in_load;
   rsp_type word_result;
   rsp_type half_result;
   rsp_type decode_result;

   // pipeline advance control
   assign out_load     = !out_valid_ff || !rsp_stall;
   assign in_load      = !in_valid_ff || out_load;
   assign req_stall    = !in_load;
   assign in_valid_in  = in_load ? req_valid : in_valid_ff;
   assign out_valid_in = out_load ? in_valid_ff : out_valid_ff;

   // decoders for both instruction sets
   dicd_word_decode u_word_decode (
      .instruction_word(in_data_ff.instruction_word),
      .result          (word_result)
   );

   dicd_half_decode u_half_decode (
      .halfword(in_data_ff.instruction_word[15:0]),
      .result  (half_result)
   );

   // instruction set select
   assign decode_result = (in_data_ff.command == SEL_HALF) ? half_result : word_result;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (in_load) begin
         in_data_ff <= req_data;
      end
      if (out_load) begin
         out_data_ff <= decode_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

/* verif/dicd_class_checker.sv */
`timescale 1ns / 100ps
// scoreboard for the dual instruction-set class decoder: watches both channels,
// predicts the class of every accepted instruction and compares returned transfers
// depends on dicd_pkg for the payload types and class codes
module dicd_class_checker
   import dicd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_data,
   output int          error_count,
   output int          pending,
   output int          compared,
   output logic [19:0] word_seen,
   output logic [19:0] half_seen
);

   localparam int PRINT_CAP = 100;

   // one outstanding decode: the instruction and its predicted class
   typedef struct packed {
      req_type item;
      rsp_type result;
   } decode_entry;

   decode_entry expected_classes[$];

   // class decode of one instruction, first matching rule wins
   function automatic rsp_type predict_class(input req_type item);
      logic [11:0] wkey;
      logic [9:0]  hkey;
      logic [1:0]  hop;
      logic [3:0]  bcond;
      rsp_type     res;
      wkey = {item.instruction_word[27:20], item.instruction_word[7:4]};
      hkey = item.instruction_word[15:6];
      hop = hkey[3:2];
      bcond = hkey[5:2];
      res.supported = 1'b1;
      res.op_class = W_UNSUP;
      if (item.command == SEL_WORD) begin
         if (wkey == 12'h121) res.op_class = W_BX;
         else if ((wkey & 12'hFBF) == 12'h109) res.op_class = W_SWP;
         else if ((wkey & 12'hFCF) == 12'h009) res.op_class = W_MUL;
         else if ((wkey & 12'hF8F) == 12'h089) res.op_class = W_MULL;
         else if ((wkey & 12'hE49) == 12'h009) begin
            // halfword transfer, register offset; SH of 00 is not a valid form
            if (wkey[2:1] == 2'b00) begin
               res.op_class = W_UNSUP;
               res.supported = 1'b0;
            end else begin
               res.op_class = W_HREG;
            end
         end else if ((wkey & 12'hE49) == 12'h049) begin
            if (wkey[2:1] == 2'b00) begin
               res.op_class = W_UNSUP;
               res.supported = 1'b0;
            end else begin
               res.op_class = W_HIMM;
            end
         end else if ((wkey & 12'hF00) == 12'hF00) res.op_class = W_SWI;
         else if ((wkey & 12'hE01) == 12'h601) begin
            res.op_class = W_UNDEF;
            res.supported = 1'b0;
         end else if ((wkey & 12'hE00) == 12'hA00) res.op_class = W_BRANCH;
         else if ((wkey & 12'hE00) == 12'h800) res.op_class = W_BLOCK;
         else if ((wkey & 12'hC00) == 12'h400) res.op_class = W_SINGLE;
         else if ((wkey & 12'hC00) == 12'h000) begin
            // status register moves sit inside the data processing space
            if ((wkey & 12'h190) == 12'h100) res.op_class = W_PSR;
            else res.op_class = W_DP;
         end else begin
            // coprocessor space
            res.op_class = W_UNSUP;
            res.supported = 1'b0;
         end
      end else begin
         if ((hkey & 10'h3FC) == 10'h37C) res.op_class = H_SWI;
         else if ((hkey & 10'h3FC) == 10'h2C0) res.op_class = H_ADDSP;
         else if ((hkey & 10'h3D8) == 10'h2D0) res.op_class = H_PUSHPOP;
         else if ((hkey & 10'h3F0) == 10'h110) begin
            // hi-register op needs a high operand; branch-exchange must not set h2
            if ((hop != HI_OP_BX && hkey[1:0] == 2'b00) || (hop == HI_OP_BX && hkey[1])) begin
               res.op_class = H_UNSUP;
               res.supported = 1'b0;
            end else begin
               res.op_class = H_HIREG;
            end
         end else if ((hkey & 10'h3F0) == 10'h100) res.op_class = H_ALU;
         else if ((hkey & 10'h3E0) == 10'h380) res.op_class = H_BRANCH;
         else if ((hkey & 10'h3E0) == 10'h120) res.op_class = H_PCLOAD;
         else if ((hkey & 10'h3E0) == 10'h060) res.op_class = H_ADDSUB;
         else if ((hkey & 10'h3C8) == 10'h140) res.op_class = H_LSREG;
         else if ((hkey & 10'h3C8) == 10'h148) res.op_class = H_LSSIGN;
         else if ((hkey & 10'h3C0) == 10'h3C0) res.op_class = H_LONGBL;
         else if ((hkey & 10'h3C0) == 10'h340) begin
            // always and never conditions are not conditional branches
            if (bcond == 4'hE || bcond == 4'hF) begin
               res.op_class = H_UNSUP;
               res.supported = 1'b0;
            end else begin
               res.op_class = H_CONDB;
            end
         end else if ((hkey & 10'h3C0) == 10'h300) res.op_class = H_MULTI;
         else if ((hkey & 10'h3C0) == 10'h280) res.op_class = H_LOADADDR;
         else if ((hkey & 10'h3C0) == 10'h240) res.op_class = H_SPLS;
         else if ((hkey & 10'h3C0) == 10'h200) res.op_class = H_LSHALF;
         else if ((hkey & 10'h380) == 10'h180) res.op_class = H_LSIMM;
         else if ((hkey & 10'h380) == 10'h080) res.op_class = H_MOVIMM;
         else if ((hkey & 10'h380) == 10'h000) res.op_class = H_SHIFT;
         else begin
            res.op_class = H_UNSUP;
            res.supported = 1'b0;
         end
      end
      return res;
   endfunction

   // one line per mismatch, printing capped for badly broken designs
   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_CAP) $display("ERROR: %0t ns: %s", $time, msg);
      error_count++;
   endtask

   // compare returned transfers, then queue predictions for new requests
   always @(posedge clock) begin
      decode_entry front;
      if (reset) begin
         expected_classes.delete();
         pending = 0;
         compared = 0;
         error_count = 0;
         word_seen = '0;
         half_seen = '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_classes.size() == 0) begin
               report_mismatch($sformatf(
                  "result transfer with nothing outstanding: class %0d supported %0d",
                  rsp_data.op_class, rsp_data.supported));
            end else begin
               front = expected_classes.pop_front();
               compared++;
               if (rsp_data.op_class !== front.result.op_class)
                  report_mismatch($sformatf("op_class for set %0d word %08h: expected %0d got %0d",
                                            front.item.command, front.item.instruction_word,
                                            front.result.op_class, rsp_data.op_class));
               if (rsp_data.supported !== front.result.supported)
                  report_mismatch($sformatf("supported for set %0d word %08h: expected %0d got %0d",
                                            front.item.command, front.item.instruction_word,
                                            front.result.supported, rsp_data.supported));
               if (front.item.command == SEL_WORD) word_seen[front.result.op_class] = 1'b1;
               else half_seen[front.result.op_class] = 1'b1;
            end
         end
         if (req_valid && !req_stall) begin
            front.item = req_data;
            front.result = predict_class(req_data);
            expected_classes.push_back(front);
         end
         pending = expected_classes.size();
      end
   end

endmodule

/* verif/dual_isa_instruction_class_decoder_tb.sv */
`timescale 1ns / 100ps
// testbench top for the dual instruction-set class decoder: directed and shaped
// random instructions with random idling; depends on dicd_pkg, the RTL and dicd_class_checker
module dual_isa_instruction_class_decoder_tb;
   import dicd_pkg::*;

   localparam int RANDOM_ITEMS   = 1950;
   localparam int CALM_TAIL      = 200;
   localparam int PHASE_LEN      = 150;
   localparam int LATENCY        = 2;
   localparam int RESET_CYCLES   = 6;
   localparam int WATCHDOG_LIMIT = 1000;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int          error_count;
   int          pending;
   int          compared;
   logic [19:0] word_seen;
   logic [19:0] half_seen;

   logic idle_en = 1'b0;
   int   stall_left = 0;
   int   idle_cycles = 0;
   int   word_items = 0;
   int   half_items = 0;

   dual_isa_instruction_class_decoder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   dicd_class_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .error_count (error_count),
      .pending     (pending),
      .compared    (compared),
      .word_seen   (word_seen),
      .half_seen   (half_seen)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // result side back-pressure in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 11);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // present one instruction and hold it until the transfer
   task automatic send_item(input req_type item);
      req_valid <= 1'b1;
      req_data <= item;
      if (item.command == SEL_WORD) word_items++;
      else half_items++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic hold_off(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   function automatic req_type fixed_item(input logic sel, input logic [31:0] word);
      req_type item;
      item.command = sel;
      item.instruction_word = word;
      return item;
   endfunction

   // 32-bit instruction carrying the given key, other bits random
   function automatic req_type word_item(input logic [11:0] key);
      logic [31:0] word;
      word = $urandom;
      word[27:20] = key[11:4];
      word[7:4] = key[3:0];
      return fixed_item(SEL_WORD, word);
   endfunction

   // 16-bit instruction carrying the given key, upper half random
   function automatic req_type half_item(input logic [9:0] key);
      logic [31:0] word;
      word = $urandom;
      word[15:6] = key;
      return fixed_item(SEL_HALF, word);
   endfunction

   // key aimed at one encoding group, free bits random
   function automatic logic [11:0] shaped_word_key();
      logic [11:0] mask;
      logic [11:0] pat;
      logic [31:0] raw;
      raw = $urandom;
      case ($urandom_range(0, 13))
         0:       {mask, pat} = {12'hFFF, 12'h121};
         1:       {mask, pat} = {12'hFBF, 12'h109};
         2:       {mask, pat} = {12'hFCF, 12'h009};
         3:       {mask, pat} = {12'hF8F, 12'h089};
         4:       {mask, pat} = {12'hE49, 12'h009};
         5:       {mask, pat} = {12'hE49, 12'h049};
         6:       {mask, pat} = {12'hF00, 12'hF00};
         7:       {mask, pat} = {12'hE01, 12'h601};
         8:       {mask, pat} = {12'hE00, 12'hA00};
         9:       {mask, pat} = {12'hE00, 12'h800};
         10:      {mask, pat} = {12'hC00, 12'h400};
         11:      {mask, pat} = {12'hC00, 12'h000};
         12:      {mask, pat} = {12'hC00, 12'hC00};
         default: {mask, pat} = {12'h000, 12'h000};
      endcase
      return (raw[11:0] & ~mask) | pat;
   endfunction

   function automatic logic [9:0] shaped_half_key();
      logic [9:0]  mask;
      logic [9:0]  pat;
      logic [31:0] raw;
      raw = $urandom;
      case ($urandom_range(0, 19))
         0:       {mask, pat} = {10'h3FC, 10'h37C};
         1:       {mask, pat} = {10'h3FC, 10'h2C0};
         2:       {mask, pat} = {10'h3D8, 10'h2D0};
         3:       {mask, pat} = {10'h3F0, 10'h110};
         4:       {mask, pat} = {10'h3F0, 10'h100};
         5:       {mask, pat} = {10'h3E0, 10'h380};
         6:       {mask, pat} = {10'h3E0, 10'h120};
         7:       {mask, pat} = {10'h3E0, 10'h060};
         8:       {mask, pat} = {10'h3C8, 10'h140};
         9:       {mask, pat} = {10'h3C8, 10'h148};
         10:      {mask, pat} = {10'h3C0, 10'h3C0};
         11:      {mask, pat} = {10'h3C0, 10'h340};
         12:      {mask, pat} = {10'h3C0, 10'h300};
         13:      {mask, pat} = {10'h3C0, 10'h280};
         14:      {mask, pat} = {10'h3C0, 10'h240};
         15:      {mask, pat} = {10'h3C0, 10'h200};
         16:      {mask, pat} = {10'h380, 10'h180};
         17:      {mask, pat} = {10'h380, 10'h080};
         18:      {mask, pat} = {10'h380, 10'h000};
         default: {mask, pat} = {10'h000, 10'h000};
      endcase
      return (raw[9:0] & ~mask) | pat;
   endfunction

   // stimulus and verdict
   initial begin
      bit busy_phase;
      bit gaps_ok;
      busy_phase = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      idle_en <= 1'b1;

      // extremes of both fields
      send_item(fixed_item(SEL_WORD, 32'h0000_0000));
      send_item(fixed_item(SEL_WORD, 32'hFFFF_FFFF));
      send_item(fixed_item(SEL_HALF, 32'h0000_0000));
      send_item(fixed_item(SEL_HALF, 32'hFFFF_FFFF));

      // one of each 32-bit group
      send_item(word_item(12'h121));
      send_item(word_item(12'h109));
      send_item(word_item(12'h009));
      send_item(word_item(12'h089));
      send_item(word_item(12'h00B));
      send_item(word_item(12'h04B));
      send_item(word_item(12'hF00));
      send_item(word_item(12'h601));
      send_item(word_item(12'hA00));
      send_item(word_item(12'h800));
      send_item(word_item(12'h400));
      send_item(word_item(12'h100));
      // halfword transfer with SH of 00, compare with S set, coprocessor space
      send_item(word_item(12'h189));
      send_item(word_item(12'h111));
      send_item(word_item(12'hC00));

      // good and bad hi-register forms, branch on always, hole in the 16-bit map
      send_item(half_item(10'h11C));
      send_item(half_item(10'h110));
      send_item(half_item(10'h11E));
      send_item(half_item(10'h378));
      send_item(half_item(10'h2C4));

      // shaped random instructions, idling off in some phases and in the tail
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % PHASE_LEN == 0) busy_phase = ($urandom_range(0, 3) != 0);
         gaps_ok = busy_phase && (i < RANDOM_ITEMS - CALM_TAIL);
         idle_en <= gaps_ok;
         if (gaps_ok && $urandom_range(0, 5) == 0) hold_off($urandom_range(1, 12));
         if ($urandom_range(0, 1) == 1) send_item(half_item(shaped_half_key()));
         else send_item(word_item(shaped_word_key()));
      end

      // drain and settle
      req_valid <= 1'b0;
      idle_en <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);

      $display("sent %0d 32-bit and %0d 16-bit instructions, %0d results compared",
               word_items, half_items, compared);
      $display("class codes reached: %0d of 14 in the 32-bit set, %0d of 20 in the 16-bit set",
               $countones(word_seen), $countones(half_seen));
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
